/* rtl/onc_pkg.sv */
// shared types, constants and width helpers for the octahedral normal codec
package onc_pkg;

	// default build widths
	localparam int IN_WIDTH_DEF = 16;
	localparam int MAX_BITS_DEF = 16;

	// configuration register
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] NB_RESET = 5'd12;

	// fixed result widths and fixed-point constants
	localparam int OUT_W     = 16;
	localparam int SQ_SHIFT  = 28;
	localparam int UNIT_ONE  = 16384;
	localparam int DEC_QB    = 15;

	// decoupling queue depth
	localparam int QUEUE_DEPTH = 4;

	// request kind
	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_DECODE = 1'b1
	} req_t;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// width of one queue entry: kind, two numerators, divisor, square sum, three components
	function automatic int entry_w(input int inw, input int mb);
		return 1 + 2 * (inw + 2 + mb) + (inw + 2) + 2 * mb + 3 * (mb + 1);
	endfunction

endpackage

/* rtl/onc_queue.sv */
// short register queue between the front and back parts
module onc_queue import onc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         nonempty
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [0:DEPTH-1];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full     = (cnt_q == CNTW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(DEPTH)) else $error("queue count beyond depth");

endmodule

/* rtl/onc_front.sv */
// front part: takes requests, folds and scales operands, feeds the queue
module onc_front import onc_pkg::*; #(
	parameter int IN_WIDTH = IN_WIDTH_DEF,
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [CFG_W-1:0]                normal_bits,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic signed [IN_WIDTH-1:0]      vec_x,
	input  logic signed [IN_WIDTH-1:0]      vec_y,
	input  logic signed [IN_WIDTH-1:0]      vec_z,
	input  logic [OUT_W-1:0]                code_a,
	input  logic [OUT_W-1:0]                code_b,
	output logic                            push,
	input  logic                            full,
	output logic [entry_w(IN_WIDTH, MAX_BITS)-1:0] push_data
);

	localparam int SW  = IN_WIDTH + 1;
	localparam int NAW = IN_WIDTH + 2;
	localparam int ENW = NAW + MAX_BITS;
	localparam int SQW = 2 * MAX_BITS;
	localparam int CW  = MAX_BITS + 1;

	// code range from the register
	logic [CFG_W-1:0]  nb_eff;
	logic [MAX_BITS:0] m_ext;
	logic [MAX_BITS-1:0] m;

	always_comb begin
		if (normal_bits == '0) begin
			nb_eff = CFG_W'(1);
		end else if (normal_bits > CFG_W'(MAX_BITS)) begin
			nb_eff = CFG_W'(MAX_BITS);
		end else begin
			nb_eff = normal_bits;
		end
		m_ext = ((MAX_BITS+1)'(1) << nb_eff) - (MAX_BITS+1)'(1);
		m     = m_ext[MAX_BITS-1:0];
	end

	// encode operand preparation
	logic [IN_WIDTH-1:0] ax, ay, az;
	logic [SW-1:0]       s;
	logic signed [NAW:0] x_e, y_e, s_e, ax_e, ay_e, na_e, nb_e;
	logic [NAW-1:0]      den;

	always_comb begin
		ax   = vec_x[IN_WIDTH-1] ? (~vec_x + 1'b1) : vec_x;
		ay   = vec_y[IN_WIDTH-1] ? (~vec_y + 1'b1) : vec_y;
		az   = vec_z[IN_WIDTH-1] ? (~vec_z + 1'b1) : vec_z;
		s    = SW'(ax) + SW'(ay) + SW'(az);
		x_e  = (NAW+1)'(vec_x);
		y_e  = (NAW+1)'(vec_y);
		s_e  = $signed((NAW+1)'(s));
		ax_e = $signed((NAW+1)'(ax));
		ay_e = $signed((NAW+1)'(ay));
		if (vec_z[IN_WIDTH-1]) begin
			na_e = vec_x[IN_WIDTH-1] ? ay_e : (s_e + s_e - ay_e);
			nb_e = vec_y[IN_WIDTH-1] ? ax_e : (s_e + s_e - ax_e);
		end else begin
			na_e = x_e + s_e;
			nb_e = y_e + s_e;
		end
		den = (s == '0) ? NAW'(1) : NAW'({s, 1'b0});
	end

	// decode operand preparation with lower-half fold
	logic [MAX_BITS-1:0]   ca, cb, au, av, mu, mv, mw;
	logic signed [MAX_BITS+1:0] m_e, u_e, v_e, w_e, au_e, av_e, uf, vf;

	always_comb begin
		ca   = (code_a > OUT_W'(m)) ? m : code_a[MAX_BITS-1:0];
		cb   = (code_b > OUT_W'(m)) ? m : code_b[MAX_BITS-1:0];
		m_e  = $signed({2'b00, m});
		u_e  = $signed({1'b0, ca, 1'b0}) - m_e;
		v_e  = $signed({1'b0, cb, 1'b0}) - m_e;
		au   = MAX_BITS'(u_e[MAX_BITS+1] ? -u_e : u_e);
		av   = MAX_BITS'(v_e[MAX_BITS+1] ? -v_e : v_e);
		au_e = $signed({2'b00, au});
		av_e = $signed({2'b00, av});
		w_e  = m_e - au_e - av_e;
		if (w_e[MAX_BITS+1]) begin
			uf = u_e[MAX_BITS+1] ? (av_e - m_e) : (m_e - av_e);
			vf = v_e[MAX_BITS+1] ? (au_e - m_e) : (m_e - au_e);
			mu = m - av;
			mv = m - au;
			mw = MAX_BITS'(-w_e);
		end else begin
			uf = u_e;
			vf = v_e;
			mu = au;
			mv = av;
			mw = MAX_BITS'(w_e);
		end
	end

	// stage registers
	logic                 vld_s1, vld_s2;
	req_t                 typ_s1, typ_s2;
	logic [NAW-1:0]       na_s1, nb_s1, den_s1, den_s2;
	logic [SW-1:0]        s_s1, s_s2;
	logic [CW-1:0]        u_s1, v_s1, w_s1, u_s2, v_s2, w_s2;
	logic [MAX_BITS-1:0]  mu_s1, mv_s1, mw_s1;
	logic [ENW-1:0]       pa_s2, pb_s2;
	logic [SQW-1:0]       su_s2, sv_s2, sw_s2;
	logic                 fen;

	assign fen      = !vld_s2 || !full;
	assign in_ready = fen;
	assign push     = vld_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (fen) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1 operands, stage 2 products
	always_ff @(posedge clk) begin
		if (fen) begin
			typ_s1 <= req_t'(req_type);
			na_s1  <= na_e[NAW-1:0];
			nb_s1  <= nb_e[NAW-1:0];
			s_s1   <= s;
			den_s1 <= den;
			u_s1   <= uf[MAX_BITS:0];
			v_s1   <= vf[MAX_BITS:0];
			w_s1   <= w_e[MAX_BITS:0];
			mu_s1  <= mu;
			mv_s1  <= mv;
			mw_s1  <= mw;
			typ_s2 <= typ_s1;
			s_s2   <= s_s1;
			den_s2 <= den_s1;
			u_s2   <= u_s1;
			v_s2   <= v_s1;
			w_s2   <= w_s1;
			pa_s2  <= ENW'(na_s1) * ENW'(m);
			pb_s2  <= ENW'(nb_s1) * ENW'(m);
			su_s2  <= SQW'(mu_s1) * SQW'(mu_s1);
			sv_s2  <= SQW'(mv_s1) * SQW'(mv_s1);
			sw_s2  <= SQW'(mw_s1) * SQW'(mw_s1);
		end
	end

	// rounding offset and square sum into the queue entry
	logic [ENW-1:0] num_a, num_b;
	logic [SQW-1:0] sq;

	always_comb begin
		num_a     = pa_s2 + ENW'(s_s2);
		num_b     = pb_s2 + ENW'(s_s2);
		sq        = su_s2 + sv_s2 + sw_s2;
		push_data = {typ_s2, num_a, num_b, den_s2, sq, u_s2, v_s2, w_s2};
	end

endmodule

/* rtl/onc_back.sv */
// back part: square root and shared three-lane divider pipelines, output register
module onc_back import onc_pkg::*; #(
	parameter int IN_WIDTH = IN_WIDTH_DEF,
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [entry_w(IN_WIDTH, MAX_BITS)-1:0] q_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         resp_type,
	output logic [OUT_W-1:0]             out_a,
	output logic [OUT_W-1:0]             out_b,
	output logic signed [OUT_W-1:0]      unit_x,
	output logic signed [OUT_W-1:0]      unit_y,
	output logic signed [OUT_W-1:0]      unit_z
);

	localparam int NAW   = IN_WIDTH + 2;
	localparam int ENW   = NAW + MAX_BITS;
	localparam int SQW   = 2 * MAX_BITS;
	localparam int CW    = MAX_BITS + 1;
	localparam int ROOTW = MAX_BITS + SQ_SHIFT / 2;
	localparam int RADW  = 2 * ROOTW;
	localparam int RMW   = ROOTW + 3;
	localparam int QB    = max2(MAX_BITS, DEC_QB);
	localparam int DECNW = MAX_BITS + SQ_SHIFT + 2;
	localparam int DENW  = max2(NAW, ROOTW + 1);
	localparam int NUMW  = max2(ENW, DECNW);
	localparam int CMPW  = max2(NUMW, DENW + QB);

	logic en;
	logic out_valid_q;

	assign en        = !out_valid_q || out_ready;
	assign pop       = en && q_valid;
	assign out_valid = out_valid_q;

	// queue entry fields
	logic           e_typ;
	logic [ENW-1:0] e_na, e_nb;
	logic [NAW-1:0] e_den;
	logic [SQW-1:0] e_sq;
	logic [CW-1:0]  e_u, e_v, e_w;

	assign {e_typ, e_na, e_nb, e_den, e_sq, e_u, e_v, e_w} = q_data;

	// square root stages, index 0 is the entry register
	logic             rt_vld_s  [0:ROOTW];
	req_t             rt_typ_s  [0:ROOTW];
	logic [ENW-1:0]   rt_na_s   [0:ROOTW];
	logic [ENW-1:0]   rt_nb_s   [0:ROOTW];
	logic [NAW-1:0]   rt_den_s  [0:ROOTW];
	logic [SQW-1:0]   rt_sq_s   [0:ROOTW];
	logic [CW-1:0]    rt_c_s    [0:ROOTW][0:2];
	logic [RMW-1:0]   rt_rem_s  [0:ROOTW];
	logic [ROOTW-1:0] rt_root_s [0:ROOTW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			rt_vld_s[0] <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_typ_s[0]  <= req_t'(e_typ);
			rt_na_s[0]   <= e_na;
			rt_nb_s[0]   <= e_nb;
			rt_den_s[0]  <= e_den;
			rt_sq_s[0]   <= e_sq;
			rt_c_s[0][0] <= e_u;
			rt_c_s[0][1] <= e_v;
			rt_c_s[0][2] <= e_w;
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
		end
	end

	// one result bit per stage, two radicand bits consumed per stage
	for (genvar k = 0; k < ROOTW; k++) begin : g_rt
		logic [RADW-1:0] rad;
		logic [RMW-1:0]  cand, trial;
		logic            ge;

		always_comb begin
			rad   = {rt_sq_s[k], SQ_SHIFT'(0)};
			cand  = {rt_rem_s[k][RMW-3:0], rad[RADW-1-2*k -: 2]};
			trial = RMW'({rt_root_s[k], 2'b01});
			ge    = (cand >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k+1] <= rt_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_typ_s[k+1]  <= rt_typ_s[k];
				rt_na_s[k+1]   <= rt_na_s[k];
				rt_nb_s[k+1]   <= rt_nb_s[k];
				rt_den_s[k+1]  <= rt_den_s[k];
				rt_sq_s[k+1]   <= rt_sq_s[k];
				rt_c_s[k+1]    <= rt_c_s[k];
				rt_rem_s[k+1]  <= ge ? (cand - trial) : cand;
				rt_root_s[k+1] <= {rt_root_s[k][ROOTW-2:0], ge};
			end
		end
	end

	// divider stages, index 0 holds the prepared operands
	logic            dv_vld_s [0:QB];
	req_t            dv_typ_s [0:QB];
	logic [DENW-1:0] dv_den_s [0:QB];
	logic [CMPW-1:0] dv_rem_s [0:QB][0:2];
	logic [QB-1:0]   dv_q_s   [0:QB][0:2];
	logic            dv_neg_s [0:QB][0:2];

	// numerator and divisor per lane
	logic [ROOTW-1:0]    r_eff;
	logic [MAX_BITS-1:0] cmag [0:2];
	logic [CMPW-1:0]     n_in [0:2];
	logic [DENW-1:0]     d_in;
	logic                neg_in [0:2];

	always_comb begin
		r_eff = (rt_root_s[ROOTW] == '0) ? ROOTW'(1) : rt_root_s[ROOTW];
		for (int l = 0; l < 3; l++) begin
			cmag[l] = MAX_BITS'(rt_c_s[ROOTW][l][CW-1] ? -rt_c_s[ROOTW][l]
				: rt_c_s[ROOTW][l]);
		end
		if (rt_typ_s[ROOTW] == REQ_DECODE) begin
			d_in = DENW'({r_eff, 1'b0});
			for (int l = 0; l < 3; l++) begin
				n_in[l]   = CMPW'({cmag[l], (SQ_SHIFT+1)'(0)}) + CMPW'(r_eff);
				neg_in[l] = rt_c_s[ROOTW][l][CW-1];
			end
		end else begin
			d_in = DENW'(rt_den_s[ROOTW]);
			n_in[0] = CMPW'(rt_na_s[ROOTW]);
			n_in[1] = CMPW'(rt_nb_s[ROOTW]);
			n_in[2] = '0;
			for (int l = 0; l < 3; l++) begin
				neg_in[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[ROOTW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_typ_s[0] <= rt_typ_s[ROOTW];
			dv_den_s[0] <= d_in;
			for (int l = 0; l < 3; l++) begin
				dv_rem_s[0][l] <= n_in[l];
				dv_q_s[0][l]   <= '0;
				dv_neg_s[0][l] <= neg_in[l];
			end
		end
	end

	// restoring division, one quotient bit per stage in each lane
	for (genvar k = 0; k < QB; k++) begin : g_dv
		logic [CMPW-1:0] trial;
		logic            ge [0:2];

		always_comb begin
			trial = CMPW'(dv_den_s[k]) << (QB - 1 - k);
			for (int l = 0; l < 3; l++) begin
				ge[l] = (dv_rem_s[k][l] >= trial);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_typ_s[k+1] <= dv_typ_s[k];
				dv_den_s[k+1] <= dv_den_s[k];
				for (int l = 0; l < 3; l++) begin
					dv_rem_s[k+1][l] <= ge[l] ? (dv_rem_s[k][l] - trial) : dv_rem_s[k][l];
					dv_q_s[k+1][l]   <= {dv_q_s[k][l][QB-2:0], ge[l]};
					dv_neg_s[k+1][l] <= dv_neg_s[k][l];
				end
			end
		end
	end

	// saturate and sign the unit components
	logic [OUT_W-1:0] umag [0:2];
	logic [OUT_W-1:0] uval [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			umag[l] = (dv_q_s[QB][l] > QB'(UNIT_ONE)) ? OUT_W'(UNIT_ONE)
				: OUT_W'(dv_q_s[QB][l]);
			uval[l] = dv_neg_s[QB][l] ? (~umag[l] + 1'b1) : umag[l];
		end
	end

	// output register
	req_t             typ_q;
	logic [OUT_W-1:0] a_q, b_q, ux_q, uy_q, uz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			typ_q <= dv_typ_s[QB];
			if (dv_typ_s[QB] == REQ_DECODE) begin
				a_q  <= '0;
				b_q  <= '0;
				ux_q <= uval[0];
				uy_q <= uval[1];
				uz_q <= uval[2];
			end else begin
				a_q  <= OUT_W'(dv_q_s[QB][0]);
				b_q  <= OUT_W'(dv_q_s[QB][1]);
				ux_q <= '0;
				uy_q <= '0;
				uz_q <= '0;
			end
		end
	end

	assign resp_type = typ_q;
	assign out_a     = a_q;
	assign out_b     = b_q;
	assign unit_x    = $signed(ux_q);
	assign unit_y    = $signed(uy_q);
	assign unit_z    = $signed(uz_q);

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rt_vld_s[ROOTW] && rt_typ_s[ROOTW] == REQ_DECODE) |-> rt_root_s[ROOTW] != '0)
		else $error("decode square root came out zero");
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld_s[QB] && dv_typ_s[QB] == REQ_DECODE) |->
		(dv_q_s[QB][0] <= QB'(UNIT_ONE) && dv_q_s[QB][1] <= QB'(UNIT_ONE)
		&& dv_q_s[QB][2] <= QB'(UNIT_ONE)))
		else $error("decode quotient above unit length");

endmodule

/* rtl/octahedral_normal_codec_top.sv */
// top level of the octahedral normal codec: configuration register and part wiring
// Octahedral normal codec. Each transaction on the input channel is either an encode
// (req_type 0: integer vector to a code pair in [0, 2^n - 1], with n being normal_bits
// clamped to 1..MAX_BITS) or a decode (req_type 1: code pair to a unit normal in Q1.14),
// and gives exactly one transaction on the output channel, in order. The block takes
// one transaction per clock cycle while the queue has room and delivers one per cycle
// while the output side is ready. The path to the output register runs through the
// square root pipeline, which resolves one result bit per stage, and the three-lane
// restoring divider, which resolves one quotient bit per stage. A four-entry queue
// between the operand front end and the arithmetic back end lets the input keep flowing
// while the output is stalled, until the queue is full.
// normal_bits is written through the cfg channel, which is always ready; write it only
// while no transaction is in flight.
module octahedral_normal_codec_top import onc_pkg::*; #(
	parameter int IN_WIDTH = IN_WIDTH_DEF,
	parameter int MAX_BITS = MAX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic signed [IN_WIDTH-1:0] vec_x,
	input  logic signed [IN_WIDTH-1:0] vec_y,
	input  logic signed [IN_WIDTH-1:0] vec_z,
	input  logic [OUT_W-1:0]           code_a,
	input  logic [OUT_W-1:0]           code_b,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       resp_type,
	output logic [OUT_W-1:0]           out_a,
	output logic [OUT_W-1:0]           out_b,
	output logic signed [OUT_W-1:0]    unit_x,
	output logic signed [OUT_W-1:0]    unit_y,
	output logic signed [OUT_W-1:0]    unit_z
);

	localparam int EW = entry_w(IN_WIDTH, MAX_BITS);

	// configuration register
	logic [CFG_W-1:0] nb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= NB_RESET;
		end else if (cfg_valid) begin
			nb_q <= cfg_data;
		end
	end

	// front part
	logic          push, full, pop, nonempty;
	logic [EW-1:0] push_data, pop_data;

	onc_front #(
		.IN_WIDTH (IN_WIDTH),
		.MAX_BITS (MAX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.normal_bits (nb_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.vec_z       (vec_z),
		.code_a      (code_a),
		.code_b      (code_b),
		.push        (push),
		.full        (full),
		.push_data   (push_data)
	);

	// decoupling queue
	onc_queue #(
		.W     (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (nonempty)
	);

	// back part
	onc_back #(
		.IN_WIDTH (IN_WIDTH),
		.MAX_BITS (MAX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (nonempty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.resp_type (resp_type),
		.out_a     (out_a),
		.out_b     (out_b),
		.unit_x    (unit_x),
		.unit_y    (unit_y),
		.unit_z    (unit_z)
	);

endmodule

/* tb/tb_top.sv */
// testbench for the octahedral normal codec: scoreboard, drivers and run sequence
`timescale 1ns / 1ps

module tb_top;
	import onc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 80;

	// one result transaction as seen on the output channel
	typedef struct packed {
		logic                    kind;
		logic [OUT_W-1:0]        code_a;
		logic [OUT_W-1:0]        code_b;
		logic signed [OUT_W-1:0] ux;
		logic signed [OUT_W-1:0] uy;
		logic signed [OUT_W-1:0] uz;
	} codec_res_t;

	// predicts codec results and checks them in order
	class normal_scoreboard;
		codec_res_t      pending_q[$];
		logic [CFG_W-1:0] code_bits;
		int              fail_cnt;
		int              enc_cnt;
		int              dec_cnt;

		function new();
			code_bits = NB_RESET;
			fail_cnt  = 0;
			enc_cnt   = 0;
			dec_cnt   = 0;
		endfunction

		function longint code_limit();
			int b;
			b = code_bits;
			if (b < 1) b = 1;
			if (b > MAX_BITS_DEF) b = MAX_BITS_DEF;
			return (64'd1 << b) - 1;
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned res;
			longint unsigned bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n   = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function logic signed [OUT_W-1:0] unit_q14(longint c, longint unsigned r);
			longint unsigned mag;
			longint unsigned q;
			mag = (c < 0) ? -c : c;
			q   = ((mag << 29) + r) / (2 * r);
			if (q > UNIT_ONE) q = UNIT_ONE;
			return (c < 0) ? -$signed(q[OUT_W-1:0]) : $signed(q[OUT_W-1:0]);
		endfunction

		// expected result of an accepted request
		function void note_request(req_t kind, logic signed [15:0] x, logic signed [15:0] y,
				logic signed [15:0] z, logic [15:0] a_in, logic [15:0] b_in);
			codec_res_t      e;
			longint          m, xi, yi, zi, s, na, nb, u, v, w, tu, tv, a, b;
			longint unsigned r;
			m = code_limit();
			e = '0;
			e.kind = kind;
			if (kind == REQ_ENCODE) begin
				enc_cnt++;
				xi = x; yi = y; zi = z;
				s = (xi < 0 ? -xi : xi) + (yi < 0 ? -yi : yi) + (zi < 0 ? -zi : zi);
				if (s != 0) begin
					// lower hemisphere unfolds onto the square corners
					if (zi < 0) begin
						na = (xi >= 0) ? 2 * s - (yi < 0 ? -yi : yi) : (yi < 0 ? -yi : yi);
						nb = (yi >= 0) ? 2 * s - (xi < 0 ? -xi : xi) : (xi < 0 ? -xi : xi);
					end else begin
						na = xi + s;
						nb = yi + s;
					end
					e.code_a = OUT_W'((na * m + s) / (2 * s));
					e.code_b = OUT_W'((nb * m + s) / (2 * s));
				end
			end else begin
				dec_cnt++;
				a = (a_in > m) ? m : a_in;
				b = (b_in > m) ? m : b_in;
				u = 2 * a - m;
				v = 2 * b - m;
				w = m - (u < 0 ? -u : u) - (v < 0 ? -v : v);
				// fold back the lower half
				if (w < 0) begin
					tu = m - (v < 0 ? -v : v);
					tv = m - (u < 0 ? -u : u);
					u  = (u >= 0) ? tu : -tu;
					v  = (v >= 0) ? tv : -tv;
				end
				r = root_floor(longint'(u * u + v * v + w * w) << 28);
				if (r == 0) r = 1;
				e.ux = unit_q14(u, r);
				e.uy = unit_q14(v, r);
				e.uz = unit_q14(w, r);
			end
			pending_q.insert(pending_q.size(), e);
		endfunction

		// compare one output transaction with the oldest prediction
		function void check_result(codec_res_t act);
			codec_res_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, act);
				fail_cnt++;
				return;
			end
			e = pending_q.pop_front();
			if (act.kind !== e.kind) begin
				$display("%0t: resp_type exp %0d got %0d", $time, e.kind, act.kind);
				fail_cnt++;
			end
			if (act.code_a !== e.code_a) begin
				$display("%0t: out_a exp %0d got %0d", $time, e.code_a, act.code_a);
				fail_cnt++;
			end
			if (act.code_b !== e.code_b) begin
				$display("%0t: out_b exp %0d got %0d", $time, e.code_b, act.code_b);
				fail_cnt++;
			end
			if (act.ux !== e.ux) begin
				$display("%0t: unit_x exp %0d got %0d", $time, e.ux, act.ux);
				fail_cnt++;
			end
			if (act.uy !== e.uy) begin
				$display("%0t: unit_y exp %0d got %0d", $time, e.uy, act.uy);
				fail_cnt++;
			end
			if (act.uz !== e.uz) begin
				$display("%0t: unit_z exp %0d got %0d", $time, e.uz, act.uz);
				fail_cnt++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              req_type;
	logic signed [15:0] vec_x, vec_y, vec_z;
	logic [OUT_W-1:0]  code_a, code_b;
	logic              out_valid;
	logic              out_ready;
	logic              resp_type;
	logic [OUT_W-1:0]  out_a, out_b;
	logic signed [OUT_W-1:0] unit_x, unit_y, unit_z;

	normal_scoreboard sb;
	bit  idle_on;
	bit  stall_go;
	int  stall_left;
	int  cycle_cnt;
	int  cfg_writes;

	octahedral_normal_codec_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .code_a(code_a), .code_b(code_b),
		.out_valid(out_valid), .out_ready(out_ready), .resp_type(resp_type),
		.out_a(out_a), .out_b(out_b), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[octahedral_normal_codec_top] ERROR");
			$finish;
		end
	end

	// receiver: random back-pressure plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_go) begin
			stall_go   = 1'b0;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !idle_on || ($urandom_range(99) >= 14);
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{resp_type, out_a, out_b, unit_x, unit_y, unit_z});
	end

	task automatic wait_drained();
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// write normal_bits while nothing is in flight
	task automatic write_bits(logic [CFG_W-1:0] val);
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.code_bits = val;
		cfg_writes++;
	endtask

	// offer one request and hold it until accepted
	task automatic send_req(req_t kind, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [15:0] a, logic [15:0] b);
		req_type <= kind;
		vec_x    <= x;
		vec_y    <= y;
		vec_z    <= z;
		code_a   <= a;
		code_b   <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(kind, x, y, z, a, b);
		if (idle_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		logic [15:0] a, b;
		longint      m;
		int          sel;
		m   = sb.code_limit();
		sel = $urandom_range(9);
		if ($urandom_range(1)) begin
			a = (sel < 8) ? 16'($urandom_range(32'(m))) : 16'($urandom);
			b = (sel < 8 || sel == 9) ? 16'($urandom_range(32'(m))) : 16'($urandom);
			send_req(REQ_DECODE, 16'($urandom), 16'($urandom), 16'($urandom), a, b);
		end else if (sel < 3) begin
			// small vectors hit zero sums and rounding ties
			send_req(REQ_ENCODE, 16'($signed($urandom_range(16)) - 8),
				16'($signed($urandom_range(16)) - 8), 16'($signed($urandom_range(16)) - 8),
				16'($urandom), 16'($urandom));
		end else begin
			send_req(REQ_ENCODE, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] bits_seq[6];
		sb         = new();
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		req_type   = 1'b0;
		vec_x      = '0;
		vec_y      = '0;
		vec_z      = '0;
		code_a     = '0;
		code_b     = '0;
		out_ready  = 1'b0;
		idle_on    = 1'b1;
		stall_go   = 1'b0;
		stall_left = 0;
		cycle_cnt  = 0;
		cfg_writes = 0;
		bits_seq   = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd12};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, axis extremes, lower hemisphere, code extremes
		send_req(REQ_ENCODE, 0, 0, 0, 0, 0);
		send_req(REQ_ENCODE, 32767, 0, 0, 0, 0);
		send_req(REQ_ENCODE, -32768, 0, 0, 0, 0);
		send_req(REQ_ENCODE, 0, 0, -32768, 0, 0);
		send_req(REQ_ENCODE, 0, 0, 1, 0, 0);
		send_req(REQ_ENCODE, -32768, -32768, -32768, 0, 0);
		send_req(REQ_ENCODE, 32767, 32767, 32767, 0, 0);
		send_req(REQ_ENCODE, 5, -3, -7, 0, 0);
		send_req(REQ_ENCODE, -5, 3, -2, 0, 0);
		send_req(REQ_ENCODE, 32767, -32768, -1, 0, 0);
		send_req(REQ_DECODE, 0, 0, 0, 0, 0);
		send_req(REQ_DECODE, 0, 0, 0, 4095, 4095);
		send_req(REQ_DECODE, 0, 0, 0, 0, 4095);
		send_req(REQ_DECODE, 0, 0, 0, 4095, 0);
		send_req(REQ_DECODE, 0, 0, 0, 2047, 2048);
		send_req(REQ_DECODE, 0, 0, 0, 65535, 65535);
		send_req(REQ_DECODE, 0, 0, 0, 1000, 3000);
		send_req(REQ_DECODE, 0, 0, 0, 4000, 100);

		// random phases over several code widths
		foreach (bits_seq[p]) begin
			write_bits(bits_seq[p]);
			idle_on = (p != 4);
			for (int i = 0; i < 75; i++) begin
				if (p == 0 && i == 10) stall_go = 1'b1;
				if (p == 1 && i == 40) begin
					in_valid <= 1'b0;
					wait_drained();
				end
				send_random();
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d encodes and %0d decodes over %0d code widths",
			sb.enc_cnt, sb.dec_cnt, cfg_writes + 1);
		$display("including out-of-range widths, oversized codes and a long output stall");
		if (sb.fail_cnt == 0 && sb.pending_q.size() == 0)
			$display("[octahedral_normal_codec_top] OK");
		else
			$display("[octahedral_normal_codec_top] ERROR");
		$finish;
	end

endmodule
